@@ rtl/cubic_spline_segment_eval_unit_assert.svh @@
// Assertion macros for the cubic spline segment evaluator.
`ifndef CUBIC_SPLINE_SEGMENT_EVAL_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_SEGMENT_EVAL_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that holds at every clock edge out of reset.
`define CSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cubic spline evaluator: assertion failed");

// Condition in one cycle implies a condition in the next.
`define CSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cubic spline evaluator: assertion failed");

`else

`define CSE_ASSERT(lbl, prop)
`define CSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/cse_pkg.sv @@
// Package: widths and payload types for the cubic spline segment evaluator.
package cse_pkg;

    localparam int COORD_BITS  = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_BITS      = T_FRAC_BITS + 1;

    // doubled coefficients and Horner partial sums
    localparam int COEF_BITS  = COORD_BITS + 5;
    localparam int HORN_BITS  = COORD_BITS + 6;
    localparam int MUL_BITS   = HORN_BITS + T_BITS + 1;
    localparam int NUM_STAGES = 7;

    localparam logic [T_BITS-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_before;
        logic signed [COORD_BITS-1:0] point_start;
        logic signed [COORD_BITS-1:0] point_end;
        logic signed [COORD_BITS-1:0] point_after;
        logic        [T_BITS-1:0]     frac_t;
    } cse_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] coord_out;
        logic                         saturated;
    } cse_out_t;

endpackage

@@ rtl/cubic_spline_segment_eval_unit.sv @@
// Top level: pipelined uniform Catmull-Rom segment evaluator, one coordinate per request.
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------
//  sample  | sample_valid / sample_ready  | cse_in_t  (p0..p3, frac_t)
//  result  | result_valid / result_ready  | cse_out_t (coord_out, saturated)
//
// Seven register stages: coefficients, then three multiply/round pairs of Horner's rule,
// the last round folding in p1 and the saturation. One request per cycle unless a stalled result backs up the pipe.
// Reset clears only the stage valid bits. A stalled result holds its stage; earlier
// stages keep moving into empty slots, so bubbles close up and nothing is lost or repeated.

`include "cubic_spline_segment_eval_unit_assert.svh"

module cubic_spline_segment_eval_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  cse_pkg::cse_in_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output cse_pkg::cse_out_t result
);
    import cse_pkg::*;

    localparam logic [MUL_BITS-1:0] HALF_T  = MUL_BITS'(1) << (T_FRAC_BITS - 1);
    localparam logic [MUL_BITS-1:0] HALF_T2 = MUL_BITS'(1) << T_FRAC_BITS;
    localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_en;

    // stage 0: coefficients
    logic signed [COORD_BITS-1:0] p1_s0_reg;
    logic signed [COEF_BITS-1:0]  c1_s0_reg, c2_s0_reg, c3_s0_reg;
    logic        [T_BITS-1:0]     t_s0_reg;
    // stage 1: c3 * t
    logic signed [MUL_BITS-1:0]   prod_s1_reg;
    logic                         neg_s1_reg;
    logic signed [COEF_BITS-1:0]  c1_s1_reg, c2_s1_reg;
    logic signed [COORD_BITS-1:0] p1_s1_reg;
    logic        [T_BITS-1:0]     t_s1_reg;
    // stage 2: h1
    logic signed [HORN_BITS-1:0]  h1_s2_reg;
    logic signed [COEF_BITS-1:0]  c1_s2_reg;
    logic signed [COORD_BITS-1:0] p1_s2_reg;
    logic        [T_BITS-1:0]     t_s2_reg;
    // stage 3: h1 * t
    logic signed [MUL_BITS-1:0]   prod_s3_reg;
    logic                         neg_s3_reg;
    logic signed [COEF_BITS-1:0]  c1_s3_reg;
    logic signed [COORD_BITS-1:0] p1_s3_reg;
    logic        [T_BITS-1:0]     t_s3_reg;
    // stage 4: h2
    logic signed [HORN_BITS-1:0]  h2_s4_reg;
    logic signed [COORD_BITS-1:0] p1_s4_reg;
    logic        [T_BITS-1:0]     t_s4_reg;
    // stage 5: h2 * t
    logic signed [MUL_BITS-1:0]   prod_s5_reg;
    logic                         neg_s5_reg;
    logic signed [COORD_BITS-1:0] p1_s5_reg;
    // stage 6: result
    logic signed [COORD_BITS-1:0] coord_reg;
    logic                         sat_reg;

    logic signed [COEF_BITS-1:0]  p0_e, p1_e, p2_e, p3_e, d12, d30;
    logic signed [COEF_BITS-1:0]  c1_next, c2_next, c3_next;
    logic        [T_BITS-1:0]     t_next;
    logic signed [T_BITS:0]       t1_s, t3_s, t5_s;
    logic signed [HORN_BITS-1:0]  c3_h, h1_h;
    logic signed [MUL_BITS-1:0]   prod1_next, prod3_next;
    logic signed [MUL_BITS-1:0]   rnd1_sum, rnd3_sum, rnd5_sum;
    logic signed [HORN_BITS-1:0]  h1_next, h2_next, y_full;
    logic signed [COORD_BITS-1:0] coord_next;
    logic                         sat_next;

    // stage enables, last to first
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || result_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (stage_en[0])
        begin
            vld_next[0] = sample_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (stage_en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sample_ready = stage_en[0];

    // ---- stage 0 ----
    always_comb
    begin
        p0_e    = COEF_BITS'(sample.point_before);
        p1_e    = COEF_BITS'(sample.point_start);
        p2_e    = COEF_BITS'(sample.point_end);
        p3_e    = COEF_BITS'(sample.point_after);
        d12     = p1_e - p2_e;
        d30     = p3_e - p0_e;
        c1_next = p2_e - p0_e;
        c2_next = (p0_e <<< 1) - (p1_e <<< 2) - p1_e + (p2_e <<< 2) - p3_e;
        c3_next = (d12 <<< 1) + d12 + d30;
        t_next  = (sample.frac_t > T_ONE) ? T_ONE : sample.frac_t;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            p1_s0_reg <= sample.point_start;
            c1_s0_reg <= c1_next;
            c2_s0_reg <= c2_next;
            c3_s0_reg <= c3_next;
            t_s0_reg  <= t_next;
        end
    end

    // ---- stage 1 ----
    assign t1_s       = $signed({1'b0, t_s0_reg});
    assign c3_h       = HORN_BITS'(c3_s0_reg);
    assign prod1_next = MUL_BITS'(c3_h) * MUL_BITS'(t1_s);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            prod_s1_reg <= prod1_next;
            neg_s1_reg  <= c3_s0_reg[COEF_BITS-1];
            c1_s1_reg   <= c1_s0_reg;
            c2_s1_reg   <= c2_s0_reg;
            p1_s1_reg   <= p1_s0_reg;
            t_s1_reg    <= t_s0_reg;
        end
    end

    // ---- stage 2 ----
    // ties away from zero: bias by half, less one for a negative multiplicand
    assign rnd1_sum = prod_s1_reg + $signed(HALF_T) - $signed(MUL_BITS'(neg_s1_reg));
    assign h1_next  = HORN_BITS'(rnd1_sum >>> T_FRAC_BITS) + HORN_BITS'(c2_s1_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            h1_s2_reg <= h1_next;
            c1_s2_reg <= c1_s1_reg;
            p1_s2_reg <= p1_s1_reg;
            t_s2_reg  <= t_s1_reg;
        end
    end

    // ---- stage 3 ----
    assign t3_s       = $signed({1'b0, t_s2_reg});
    assign h1_h       = h1_s2_reg;
    assign prod3_next = MUL_BITS'(h1_h) * MUL_BITS'(t3_s);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            prod_s3_reg <= prod3_next;
            neg_s3_reg  <= h1_s2_reg[HORN_BITS-1];
            c1_s3_reg   <= c1_s2_reg;
            p1_s3_reg   <= p1_s2_reg;
            t_s3_reg    <= t_s2_reg;
        end
    end

    // ---- stage 4 ----
    assign rnd3_sum = prod_s3_reg + $signed(HALF_T) - $signed(MUL_BITS'(neg_s3_reg));
    assign h2_next  = HORN_BITS'(rnd3_sum >>> T_FRAC_BITS) + HORN_BITS'(c1_s3_reg);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            h2_s4_reg <= h2_next;
            p1_s4_reg <= p1_s3_reg;
            t_s4_reg  <= t_s3_reg;
        end
    end

    // ---- stage 5 ----
    assign t5_s = $signed({1'b0, t_s4_reg});

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            prod_s5_reg <= MUL_BITS'(h2_s4_reg) * MUL_BITS'(t5_s);
            neg_s5_reg  <= h2_s4_reg[HORN_BITS-1];
            p1_s5_reg   <= p1_s4_reg;
        end
    end

    // ---- stage 6: final round (extra halving), add p1, clip ----
    always_comb
    begin
        rnd5_sum = prod_s5_reg + $signed(HALF_T2) - $signed(MUL_BITS'(neg_s5_reg));
        y_full   = HORN_BITS'(rnd5_sum >>> (T_FRAC_BITS + 1)) + HORN_BITS'(p1_s5_reg);
        sat_next = (y_full[HORN_BITS-1:COORD_BITS-1] != '0)
                && (y_full[HORN_BITS-1:COORD_BITS-1] != '1);
        if (!sat_next)
        begin
            coord_next = y_full[COORD_BITS-1:0];
        end
        else if (y_full[HORN_BITS-1])
        begin
            coord_next = SAT_MIN;
        end
        else
        begin
            coord_next = SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            coord_reg <= coord_next;
            sat_reg   <= sat_next;
        end
    end

    assign result_valid     = vld_reg[NUM_STAGES-1];
    assign result.coord_out = coord_reg;
    assign result.saturated = sat_reg;

    `CSE_ASSERT_NEXT(a_stage_advance, vld_reg[0] && stage_en[1], vld_reg[1])
    `CSE_ASSERT_NEXT(a_stall_holds, vld_reg[3] && !stage_en[3], vld_reg[3] && $stable(prod_s3_reg))
    `CSE_ASSERT(a_t_clamped, !vld_reg[1] || (t_s1_reg <= T_ONE))
    `CSE_ASSERT(a_sat_value, !(result_valid && result.saturated) || (result.coord_out == SAT_MIN) || (result.coord_out == SAT_MAX))

endmodule
